// ----- rtl/jsed_pkg.sv -----
// Shared types for the JSON string escape decoder.
// Defines the work entry passed from the front end through the queue to the back end.
// No dependencies.
package jsed_pkg;

  // What a queued entry asks the back end to emit
  typedef enum logic [1:0] {
    KIND_BYTE = 2'd0,  // one literal byte in data[7:0]
    KIND_CP   = 2'd1,  // code point in data, emitted as 1..3 UTF-8 bytes
    KIND_ERR  = 2'd2   // bad hex digit: one zero byte with the error flag
  } entry_kind_t;

  typedef struct packed {
    entry_kind_t kind;
    logic [15:0] data;
  } entry_t;

  // UTF-8 encoding constants
  localparam logic [7:0]  UTF8_LEAD2 = 8'hC0;
  localparam logic [7:0]  UTF8_LEAD3 = 8'hE0;
  localparam logic [7:0]  UTF8_CONT  = 8'h80;
  localparam logic [15:0] CP_ONE_MAX = 16'h0080;
  localparam logic [15:0] CP_TWO_MAX = 16'h0800;

endpackage

// ----- rtl/jsed_front.sv -----
// Front end of the JSON string escape decoder: accepts raw bytes and tracks escape mode.
// Pushes one work entry per producing byte into the queue. Depends on jsed_pkg.
module jsed_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [7:0]        in_byte,
  input  logic              q_full,
  output logic              push,
  output jsed_pkg::entry_t  push_entry
);

  typedef enum logic [2:0] {
    ST_NORMAL = 3'd0,
    ST_ESCAPE = 3'd1,
    ST_HEX0   = 3'd2,
    ST_HEX1   = 3'd3,
    ST_HEX2   = 3'd4,
    ST_HEX3   = 3'd5
  } mode_t;

  mode_t       mode, mode_next;
  logic [11:0] acc, acc_next;
  logic        accept;
  logic        is_hex;
  logic [3:0]  hex_val;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;

  // Hex digit decode, either case
  always_comb begin
    is_hex  = 1'b1;
    hex_val = 4'd0;
    if (in_byte >= "0" && in_byte <= "9") begin
      hex_val = 4'(in_byte - 8'h30);
    end else if (in_byte >= "a" && in_byte <= "f") begin
      hex_val = 4'(in_byte - 8'h57);
    end else if (in_byte >= "A" && in_byte <= "F") begin
      hex_val = 4'(in_byte - 8'h37);
    end else begin
      is_hex = 1'b0;
    end
  end

  // Mode transitions and entry generation
  always_comb begin
    mode_next       = mode;
    acc_next        = acc;
    push            = 1'b0;
    push_entry.kind = jsed_pkg::KIND_BYTE;
    push_entry.data = {8'h00, in_byte};
    if (accept) begin
      unique case (mode)
        ST_ESCAPE: begin
          mode_next = ST_NORMAL;
          push      = 1'b1;
          unique case (in_byte)
            "b": push_entry.data = 16'h0008;
            "f": push_entry.data = 16'h000C;
            "n": push_entry.data = 16'h000A;
            "r": push_entry.data = 16'h000D;
            "t": push_entry.data = 16'h0009;
            "u": begin
              mode_next = ST_HEX0;
              acc_next  = 12'd0;
              push      = 1'b0;
            end
            default: push_entry.data = {8'h00, in_byte};
          endcase
        end
        ST_HEX0, ST_HEX1, ST_HEX2, ST_HEX3: begin
          if (!is_hex) begin
            mode_next       = ST_NORMAL;
            acc_next        = 12'd0;
            push            = 1'b1;
            push_entry.kind = jsed_pkg::KIND_ERR;
            push_entry.data = 16'h0000;
          end else if (mode == ST_HEX3) begin
            mode_next       = ST_NORMAL;
            acc_next        = 12'd0;
            push            = 1'b1;
            push_entry.kind = jsed_pkg::KIND_CP;
            push_entry.data = {acc, hex_val};
          end else begin
            acc_next  = {acc[7:0], hex_val};
            mode_next = mode_t'(mode + 3'd1);
          end
        end
        default: begin
          // normal mode
          if (in_byte == "\\") begin
            mode_next = ST_ESCAPE;
          end else begin
            mode_next = ST_NORMAL;
            push      = 1'b1;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= ST_NORMAL;
      acc  <= 12'd0;
    end else begin
      mode <= mode_next;
      acc  <= acc_next;
    end
  end

endmodule

// ----- rtl/jsed_fifo.sv -----
// Short work queue between front and back end of the escape decoder.
// Circular buffer of entries with occupancy count. Depends on jsed_pkg.
module jsed_fifo #(
  parameter int DEPTH = 4
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  jsed_pkg::entry_t  push_entry,
  output logic              full,
  input  logic              pop,
  output logic              head_valid,
  output jsed_pkg::entry_t  head
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  jsed_pkg::entry_t mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push, do_pop;

  assign full       = (count == CNT_W'(DEPTH));
  assign head_valid = (count != '0);
  assign head       = mem[rd_ptr];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  // Storage write
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_entry;
    end
  end

  // Pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ----- rtl/jsed_back.sv -----
// Back end of the escape decoder: expands queued entries into output bytes, one
// per cycle unless stalled, to a registered output stage. Depends on jsed_pkg.
module jsed_back (
  input  logic              clk,
  input  logic              rst,
  input  logic              head_valid,
  input  jsed_pkg::entry_t  head,
  output logic              pop,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [7:0]        out_byte,
  output logic              out_last,
  output logic              out_error
);

  logic [1:0] idx;        // byte position within the current entry
  logic       load;
  logic [7:0] byte_sel;
  logic       last_sel;
  logic       err_sel;
  logic [15:0] cp;

  assign cp   = head.data;
  assign load = head_valid && (!out_valid || out_ready);
  assign pop  = load && last_sel;

  // Select the byte for the current position
  always_comb begin
    byte_sel = 8'h00;
    last_sel = 1'b1;
    err_sel  = 1'b0;
    unique case (head.kind)
      jsed_pkg::KIND_CP: begin
        if (cp < jsed_pkg::CP_ONE_MAX) begin
          byte_sel = cp[7:0];
        end else if (cp < jsed_pkg::CP_TWO_MAX) begin
          if (idx == 2'd0) begin
            byte_sel = jsed_pkg::UTF8_LEAD2 | {3'b000, cp[10:6]};
            last_sel = 1'b0;
          end else begin
            byte_sel = jsed_pkg::UTF8_CONT | {2'b00, cp[5:0]};
          end
        end else begin
          if (idx == 2'd0) begin
            byte_sel = jsed_pkg::UTF8_LEAD3 | {4'h0, cp[15:12]};
            last_sel = 1'b0;
          end else if (idx == 2'd1) begin
            byte_sel = jsed_pkg::UTF8_CONT | {2'b00, cp[11:6]};
            last_sel = 1'b0;
          end else begin
            byte_sel = jsed_pkg::UTF8_CONT | {2'b00, cp[5:0]};
          end
        end
      end
      jsed_pkg::KIND_ERR: begin
        err_sel = 1'b1;
      end
      default: begin
        byte_sel = cp[7:0];
      end
    endcase
  end

  // Position counter and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      idx       <= 2'd0;
      out_valid <= 1'b0;
    end else begin
      if (load) begin
        out_valid <= 1'b1;
        idx       <= last_sel ? 2'd0 : idx + 2'd1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_byte  <= byte_sel;
      out_last  <= last_sel;
      out_error <= err_sel;
    end
  end

endmodule

// ----- rtl/json_string_escape_decoder_core.sv -----
// Top level of the JSON string escape decoder: front end, work queue and back end.
// Depends on jsed_pkg, jsed_front, jsed_fifo and jsed_back.
//
// Takes one raw byte of a JSON string body per transaction and emits the unescaped
// bytes, with \uXXXX escapes written out as one to three UTF-8 bytes. A byte is
// accepted whenever the work queue between front and back end has room, so input
// runs at one byte per cycle; output runs at one byte per cycle unless stalled,
// and a three-byte UTF-8 sequence holds the back end until all three are out.
// tlast marks the final output byte produced by one input byte; tuser flags a bad
// hex digit, which gives a single zero byte and returns the decoder to normal mode.
// An input byte reaches the output through the work queue and then the output register.
module json_string_escape_decoder_core #(
  parameter int FIFO_DEPTH = 4
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,   // [7:0] in_byte
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata,   // [7:0] out_byte
  output logic       m_tlast,
  output logic       m_tuser    // [0] error
);

  logic             q_full;
  logic             push;
  jsed_pkg::entry_t push_entry;
  logic             pop;
  logic             head_valid;
  jsed_pkg::entry_t head;

  jsed_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_tvalid),
    .in_ready   (s_tready),
    .in_byte    (s_tdata),
    .q_full     (q_full),
    .push       (push),
    .push_entry (push_entry)
  );

  jsed_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .full       (q_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head       (head)
  );

  jsed_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop),
    .out_valid  (m_tvalid),
    .out_ready  (m_tready),
    .out_byte   (m_tdata),
    .out_last   (m_tlast),
    .out_error  (m_tuser)
  );

endmodule
